FILE: hw/rtl/e2g_pkg.sv
// Package: shared constants and arctangent table function for the ECEF conversion.
`timescale 1ns / 1ps

package e2g_pkg;

  localparam int CORDIC_STAGES = 32;
  localparam int POS_W = 40;
  localparam int RAD_W = 39;
  localparam int GUARD_BITS = 16;
  localparam int X_W = 60;
  localparam int ANG_W = 62;
  localparam int SIDE_W = 56;
  localparam int ANG_OUT_W = 32;
  localparam int ALT_W = 40;
  localparam int ANG_SHIFT = 30;

  localparam logic [RAD_W-1:0] RADIUS_RESET = 39'd1630976000;
  localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;
  localparam logic [63:0] INV_PI = 64'h517CC1B727220A95;
  localparam logic [ANG_W-1:0] ANG_PI = ANG_W'(1) << 61;
  localparam logic [ANG_W-1:0] ANG_HALF_LSB = ANG_W'(1) << (ANG_SHIFT - 1);

  function automatic logic [63:0] div_small(input logic [63:0] num, input logic [7:0] den);
    logic [8:0] rem;
    logic [63:0] q;
    rem = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[7:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [ANG_W-1:0] angle_entry(input int i);
    logic [63:0] acc;
    logic [63:0] term;
    logic [127:0] prod;
    int n;
    int e;
    acc = '0;
    if (i == 0) begin
      return ANG_W'(1) << 59;
    end
    for (int k = 0; k < 32; k++) begin
      n = 2 * k + 1;
      e = 62 - n * i;
      if (e >= 0) begin
        term = div_small(64'd1 << e, 8'(n));
        if ((k % 2) == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
    end
    prod = {64'd0, acc} * {64'd0, INV_PI};
    return ANG_W'(prod[127:65]);
  endfunction

endpackage

FILE: hw/rtl/e2g_pass.sv
// One CORDIC vectoring pass, one stage per register, followed by gain removal.
`timescale 1ns / 1ps

module e2g_pass (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic signed [e2g_pkg::X_W-1:0]        in_x,
  input  logic signed [e2g_pkg::X_W-1:0]        in_y,
  input  logic        [e2g_pkg::ANG_W-1:0]      in_a,
  input  logic                                  in_byp,
  input  logic        [e2g_pkg::SIDE_W-1:0]     in_side,
  output logic                                  out_valid,
  output logic signed [e2g_pkg::X_W-1:0]        out_x,
  output logic        [e2g_pkg::ANG_W-1:0]      out_a,
  output logic        [e2g_pkg::SIDE_W-1:0]     out_side
);

  localparam int N = e2g_pkg::CORDIC_STAGES;

  logic [N+2:0] vld;
  logic signed [e2g_pkg::X_W-1:0] xs [N+1];
  logic signed [e2g_pkg::X_W-1:0] ys [N+1];
  logic [e2g_pkg::ANG_W-1:0] as_ [N+1];
  logic [N:0] byp;
  logic [e2g_pkg::SIDE_W-1:0] side [N+1];

  logic [63:0] xu;
  logic [63:0] ph;
  logic [63:0] pl;
  logic signed [e2g_pkg::X_W-1:0] g_x;
  logic [e2g_pkg::ANG_W-1:0] g_a;
  logic g_byp;
  logic [e2g_pkg::SIDE_W-1:0] g_side;
  logic [63:0] gain_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N+1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= in_x;
      ys[0] <= in_y;
      as_[0] <= in_a;
      byp[0] <= in_byp;
      side[0] <= in_side;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic [e2g_pkg::ANG_W-1:0] T = e2g_pkg::angle_entry(i);
    logic signed [e2g_pkg::X_W-1:0] tx;
    logic signed [e2g_pkg::X_W-1:0] ty;
    assign tx = xs[i] >>> i;
    assign ty = ys[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        byp[i+1] <= byp[i];
        side[i+1] <= side[i];
        if (byp[i]) begin
          xs[i+1] <= xs[i];
          ys[i+1] <= ys[i];
          as_[i+1] <= as_[i];
        end else if (!ys[i][e2g_pkg::X_W-1]) begin
          xs[i+1] <= xs[i] + ty;
          ys[i+1] <= ys[i] - tx;
          as_[i+1] <= as_[i] + T;
        end else begin
          xs[i+1] <= xs[i] - ty;
          ys[i+1] <= ys[i] + tx;
          as_[i+1] <= as_[i] - T;
        end
      end
    end
  end

  assign xu = 64'(xs[N]);
  assign gain_sum = ph + {32'd0, pl[63:32]};

  always_ff @(posedge clk) begin
    if (en) begin
      ph <= {32'd0, xu[63:32]} * {32'd0, e2g_pkg::INV_GAIN};
      pl <= {32'd0, xu[31:0]} * {32'd0, e2g_pkg::INV_GAIN};
      g_x <= xs[N];
      g_a <= as_[N];
      g_byp <= byp[N];
      g_side <= side[N];
      out_x <= g_byp ? g_x : e2g_pkg::X_W'(gain_sum);
      out_a <= g_a;
      out_side <= g_side;
    end
  end

  assign out_valid = vld[N+2];

endmodule

FILE: hw/rtl/ecef_to_geocentric_lat_lon_alt_unit.sv
// Top level: ECEF position to geocentric latitude, longitude and altitude.
`timescale 1ns / 1ps

// The unit accepts one position per clock cycle while in_stall is low. Each of the two
// chained CORDIC pipelines has an input register, one register stage per iteration and two
// gain-removal stages, and one output register follows them. When the output beat is held
// by stall the whole pipeline freezes and input stall rises in the same cycle. The sphere
// radius register should be written only while no positions are in flight.
module ecef_to_geocentric_lat_lon_alt_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic        [e2g_pkg::RAD_W-1:0]   cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [e2g_pkg::POS_W-1:0]   position_x,
  input  logic signed [e2g_pkg::POS_W-1:0]   position_y,
  input  logic signed [e2g_pkg::POS_W-1:0]   position_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [e2g_pkg::ANG_OUT_W-1:0] latitude,
  output logic signed [e2g_pkg::ANG_OUT_W-1:0] longitude,
  output logic signed [e2g_pkg::ALT_W-1:0]   altitude,
  output logic                               altitude_saturated
);

  localparam int XW = e2g_pkg::X_W;
  localparam int AW = e2g_pkg::ANG_W;
  localparam int SW = e2g_pkg::SIDE_W;
  localparam int OW = e2g_pkg::ANG_OUT_W;
  localparam int LW = e2g_pkg::ALT_W + 5;
  localparam logic signed [OW-1:0] LAT_MAX = OW'(1) << 30;
  localparam logic signed [OW-1:0] LAT_MIN = -LAT_MAX;
  localparam logic signed [LW-1:0] ALT_MAX = LW'((64'd1 << (e2g_pkg::ALT_W - 1)) - 64'd1);
  localparam logic signed [LW-1:0] ALT_MIN = -ALT_MAX - LW'(1);

  logic en;
  logic [e2g_pkg::RAD_W-1:0] radius;

  logic signed [XW-1:0] sx;
  logic signed [XW-1:0] sy;
  logic signed [XW-1:0] sz;
  logic x_neg;
  logic signed [XW-1:0] p1_x;
  logic signed [XW-1:0] p1_y;
  logic [AW-1:0] p1_a;

  logic v1;
  logic signed [XW-1:0] r1_x;
  logic [AW-1:0] r1_a;
  logic [SW-1:0] r1_side;
  logic [AW-1:0] lon_round;
  logic signed [XW-1:0] p2_y;

  logic v2;
  logic signed [XW-1:0] r2_x;
  logic [AW-1:0] r2_a;
  logic [SW-1:0] r2_side;
  logic [AW-1:0] lat_round;
  logic signed [OW-1:0] lat_s;
  logic signed [OW-1:0] lat_c;
  logic signed [XW-1:0] r_round;
  logic signed [LW-1:0] alt_w;
  logic signed [LW-1:0] alt_c;
  logic alt_sat;

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= e2g_pkg::RADIUS_RESET;
    end else if (cfg_write) begin
      radius <= cfg_data;
    end
  end

  assign sx = XW'(position_x) <<< e2g_pkg::GUARD_BITS;
  assign sy = XW'(position_y) <<< e2g_pkg::GUARD_BITS;
  assign sz = XW'(position_z) <<< e2g_pkg::GUARD_BITS;
  assign x_neg = position_x[e2g_pkg::POS_W-1];
  assign p1_x = x_neg ? -sx : sx;
  assign p1_y = x_neg ? -sy : sy;
  assign p1_a = x_neg ? e2g_pkg::ANG_PI : '0;

  e2g_pass u_lon (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .in_x     (p1_x),
    .in_y     (p1_y),
    .in_a     (p1_a),
    .in_byp   (position_y == '0),
    .in_side  (SW'(sz)),
    .out_valid(v1),
    .out_x    (r1_x),
    .out_a    (r1_a),
    .out_side (r1_side)
  );

  assign lon_round = r1_a + e2g_pkg::ANG_HALF_LSB;
  assign p2_y = XW'($signed(r1_side));

  e2g_pass u_lat (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v1),
    .in_x     (r1_x),
    .in_y     (p2_y),
    .in_a     ('0),
    .in_byp   (r1_side == '0),
    .in_side  (SW'(lon_round[AW-1:e2g_pkg::ANG_SHIFT])),
    .out_valid(v2),
    .out_x    (r2_x),
    .out_a    (r2_a),
    .out_side (r2_side)
  );

  assign lat_round = r2_a + e2g_pkg::ANG_HALF_LSB;
  assign lat_s = $signed(lat_round[AW-1:e2g_pkg::ANG_SHIFT]);
  assign lat_c = (lat_s > LAT_MAX) ? LAT_MAX : ((lat_s < LAT_MIN) ? LAT_MIN : lat_s);
  assign r_round = (r2_x + (XW'(1) <<< (e2g_pkg::GUARD_BITS - 1))) >>> e2g_pkg::GUARD_BITS;
  assign alt_w = LW'(r_round) - $signed({{(LW - e2g_pkg::RAD_W){1'b0}}, radius});
  assign alt_sat = (alt_w > ALT_MAX) || (alt_w < ALT_MIN);
  assign alt_c = (alt_w > ALT_MAX) ? ALT_MAX : ((alt_w < ALT_MIN) ? ALT_MIN : alt_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      latitude <= lat_c;
      longitude <= $signed(r2_side[OW-1:0]);
      altitude <= alt_c[e2g_pkg::ALT_W-1:0];
      altitude_saturated <= alt_sat;
    end
  end

`ifndef SYNTHESIS
  a_lat_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (latitude <= LAT_MAX && latitude >= LAT_MIN))
    else $error("latitude beyond a quarter turn");

  a_sat_clamp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && altitude_saturated) |->
      (altitude == ALT_MAX[e2g_pkg::ALT_W-1:0] || altitude == ALT_MIN[e2g_pkg::ALT_W-1:0]))
    else $error("saturated altitude not at a range limit");

  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat valid straight after reset");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> ($stable(v2) && $stable(v1)))
    else $error("pipeline moved while the output beat was held");
`endif

endmodule
